@@ hdl/keypad_code_lock_with_time_edit_top_assert.svh @@
// assertion macros for the keypad code lock
// all checks are clocked on clk_i and idle while rst_ni is low
`ifndef KEYPAD_CODE_LOCK_WITH_TIME_EDIT_TOP_ASSERT_SVH
`define KEYPAD_CODE_LOCK_WITH_TIME_EDIT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define KCL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KCL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KCL_ASSERT(name, prop, msg)
`define KCL_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

@@ hdl/kcl_pkg.sv @@
package kcl_pkg;

  // parameter defaults
  localparam int unsigned SCAN_DIVIDE_DEF = 3;
  localparam int unsigned CODE_LENGTH_DEF = 4;

  // register reset values
  localparam logic [31:0] ACCESS_CODE_RST   = 32'd892940595;
  localparam logic [7:0]  ENTRY_TIMEOUT_RST = 8'd30;
  localparam logic [7:0]  DENIED_HOLD_RST   = 8'd20;
  localparam logic [7:0]  GRANTED_HOLD_RST  = 8'd30;

  // key codes
  localparam logic [7:0] KEY_ZERO = 8'h30;
  localparam logic [7:0] KEY_NINE = 8'h39;
  localparam logic [7:0] KEY_A    = 8'h41;
  localparam logic [7:0] KEY_B    = 8'h42;
  localparam logic [7:0] KEY_C    = 8'h43;
  localparam logic [7:0] KEY_D    = 8'h44;
  localparam logic [7:0] KEY_HASH = 8'h23;

  // time field limits
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;

  localparam logic [3:0] MODE_IDLE = 4'd0;

  typedef enum logic [1:0] {
    FIELD_HOUR = 2'd0,
    FIELD_MIN  = 2'd1,
    FIELD_SEC  = 2'd2
  } field_e;

  typedef enum logic [1:0] {
    REG_ACCESS_CODE   = 2'd0,
    REG_ENTRY_TIMEOUT = 2'd1,
    REG_DENIED_HOLD   = 2'd2,
    REG_GRANTED_HOLD  = 2'd3
  } reg_idx_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ENTRY   = 6'b000010,
    ST_CHECK   = 6'b000100,
    ST_GRANTED = 6'b001000,
    ST_DENIED  = 6'b010000,
    ST_EDIT    = 6'b100000
  } state_e;

endpackage

@@ hdl/keypad_code_lock_with_time_edit_top.sv @@
// Keypad code lock with time-of-day editing. Each input transfer is one tick plus the keypad
// scan result; every tick yields exactly one result transfer carrying the mode after the tick,
// the edit digit count and an optional hour/minute/second write. An accepted transfer is held
// in an input register and then processed into the result register, so the block takes one
// transfer per cycle while the result output is not stalled; the lock state update is the
// only loop. The four settings registers sit on an APB port with no wait states and should be
// written only while no transfer is in flight.
`include "keypad_code_lock_with_time_edit_top_assert.svh"

module keypad_code_lock_with_time_edit_top
  import kcl_pkg::*;
#(
  parameter int unsigned SCAN_DIVIDE = SCAN_DIVIDE_DEF,
  parameter int unsigned CODE_LENGTH = CODE_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb settings port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        key_pressed_i,
  input  logic [7:0]  key_code_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  lock_mode_o,
  output logic [1:0]  edit_digits_o,
  output logic        set_valid_o,
  output logic [1:0]  set_field_o,
  output logic [5:0]  set_value_o
);

  localparam int unsigned PhW  = (SCAN_DIVIDE > 1) ? $clog2(SCAN_DIVIDE) : 1;
  localparam int unsigned PosW = $clog2(CODE_LENGTH + 1);
  localparam logic [PhW:0]    SCAN_LAST = (PhW + 1)'(SCAN_DIVIDE);
  localparam logic [PosW-1:0] POS_LAST  = PosW'(CODE_LENGTH);
  localparam logic [3:0] MODE_CHECK   = 4'(CODE_LENGTH);
  localparam logic [3:0] MODE_GRANTED = 4'(CODE_LENGTH + 1);
  localparam logic [3:0] MODE_DENIED  = 4'(CODE_LENGTH + 2);
  localparam logic [3:0] MODE_EDIT_H  = 4'(CODE_LENGTH + 3);

  // settings registers
  logic [31:0] access_code_q;
  logic [7:0]  entry_timeout_q, denied_hold_q, granted_hold_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_code_q   <= ACCESS_CODE_RST;
      entry_timeout_q <= ENTRY_TIMEOUT_RST;
      denied_hold_q   <= DENIED_HOLD_RST;
      granted_hold_q  <= GRANTED_HOLD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_ACCESS_CODE:   access_code_q   <= pwdata;
        REG_ENTRY_TIMEOUT: entry_timeout_q <= pwdata[7:0];
        REG_DENIED_HOLD:   denied_hold_q   <= pwdata[7:0];
        REG_GRANTED_HOLD:  granted_hold_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_ACCESS_CODE:   prdata = access_code_q;
      REG_ENTRY_TIMEOUT: prdata = {24'd0, entry_timeout_q};
      REG_DENIED_HOLD:   prdata = {24'd0, denied_hold_q};
      REG_GRANTED_HOLD:  prdata = {24'd0, granted_hold_q};
      default:           prdata = '0;
    endcase
  end

  // input register and stage handshake
  logic       in_valid_q, out_valid_q, advance;
  logic       pressed_q;
  logic [7:0] key_q;

  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pressed_q <= key_pressed_i;
      key_q     <= key_code_i;
    end
  end

  // lock state
  state_e          state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      field_q, field_d;
  logic [7:0]      tick_q, tick_d;
  logic [PhW-1:0]  phase_q, phase_d;
  logic [1:0]      ecnt_q, ecnt_d;
  logic [7:0]      code_q [CODE_LENGTH];
  logic [3:0]      ebuf_q [2];

  // code compare, positions without a byte in the access code register always match
  logic [CODE_LENGTH-1:0] byte_ok;
  logic                   code_match;

  for (genvar gi = 0; gi < CODE_LENGTH; gi++) begin : g_cmp
    if (CODE_LENGTH - 1 - gi < 4) begin : g_chk
      assign byte_ok[gi] = (code_q[gi] == access_code_q[8*(CODE_LENGTH-1-gi) +: 8]);
    end else begin : g_free
      assign byte_ok[gi] = 1'b1;
    end
  end
  assign code_match = &byte_ok;

  // key sampling divider
  logic [PhW:0]   phase_inc;
  logic           scan_hit;
  logic           key_hit;
  logic           is_digit;
  logic [7:0]     own_key;
  logic [6:0]     edit_value;
  logic [6:0]     edit_limit;

  assign phase_inc  = {1'b0, phase_q} + (PhW + 1)'(1);
  assign scan_hit   = (phase_inc >= SCAN_LAST);
  assign key_hit    = scan_hit & pressed_q;
  assign is_digit   = (key_q >= KEY_ZERO) && (key_q <= KEY_NINE);
  assign own_key    = KEY_A + {6'd0, field_q};
  assign edit_value = ({3'd0, ebuf_q[0]} << 3) + ({3'd0, ebuf_q[0]} << 1)
                    + {3'd0, ebuf_q[1]};
  assign edit_limit = (field_q == FIELD_HOUR) ? HOUR_MAX : MINSEC_MAX;

  logic       code_wr, ebuf_wr;
  logic       set_valid_d;
  logic [1:0] set_field_d;
  logic [5:0] set_value_d;
  logic [3:0] lock_mode_d;
  logic [7:0] tick_mid;

  // next state for one tick
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    field_d     = field_q;
    tick_d      = tick_q + 8'd1;
    phase_d     = phase_q;
    ecnt_d      = ecnt_q;
    code_wr     = 1'b0;
    ebuf_wr     = 1'b0;
    set_valid_d = 1'b0;
    set_field_d = 2'd0;
    set_value_d = 6'd0;
    tick_mid    = tick_q + 8'd1;
    if (state_q == ST_IDLE || state_q == ST_ENTRY || state_q == ST_EDIT) begin
      phase_d = scan_hit ? '0 : phase_inc[PhW-1:0];
    end
    unique case (state_q)
      ST_IDLE: begin
        if (key_hit) begin
          code_wr = 1'b1;
          case (key_q)
            KEY_A: begin state_d = ST_EDIT; field_d = FIELD_HOUR; tick_d = '0; end
            KEY_B: begin state_d = ST_EDIT; field_d = FIELD_MIN;  tick_d = '0; end
            KEY_C: begin state_d = ST_EDIT; field_d = FIELD_SEC;  tick_d = '0; end
            KEY_D: tick_d = '0;
            default: begin
              if (is_digit) begin
                tick_d  = '0;
                pos_d   = PosW'(1);
                state_d = (pos_d == POS_LAST) ? ST_CHECK : ST_ENTRY;
              end
            end
          endcase
        end
      end
      ST_ENTRY: begin
        if (key_hit) begin
          code_wr  = 1'b1;
          tick_mid = '0;
          pos_d    = pos_q + PosW'(1);
          state_d  = (pos_d == POS_LAST) ? ST_CHECK : ST_ENTRY;
        end
        tick_d = tick_mid;
        if (tick_mid == entry_timeout_q) begin
          tick_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        tick_d  = '0;
        state_d = code_match ? ST_GRANTED : ST_DENIED;
      end
      ST_GRANTED: begin
        if (tick_mid == granted_hold_q) begin
          tick_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_DENIED: begin
        if (tick_mid == denied_hold_q) begin
          tick_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_EDIT: begin
        if (key_hit) begin
          code_wr = 1'b1;
          if (key_q == own_key) begin
            if (ecnt_q == 2'd2 && edit_value <= edit_limit) begin
              set_valid_d = 1'b1;
              set_field_d = field_q;
              set_value_d = edit_value[5:0];
            end
            ecnt_d  = 2'd0;
            state_d = ST_IDLE;
          end else if (key_q == KEY_HASH) begin
            ecnt_d  = 2'd0;
            state_d = ST_IDLE;
          end else if (is_digit && ecnt_q < 2'd2) begin
            ebuf_wr = 1'b1;
            ecnt_d  = ecnt_q + 2'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // mode code seen by the user
  always_comb begin
    unique case (state_d)
      ST_IDLE:    lock_mode_d = MODE_IDLE;
      ST_ENTRY:   lock_mode_d = 4'(pos_d);
      ST_CHECK:   lock_mode_d = MODE_CHECK;
      ST_GRANTED: lock_mode_d = MODE_GRANTED;
      ST_DENIED:  lock_mode_d = MODE_DENIED;
      ST_EDIT:    lock_mode_d = MODE_EDIT_H + {2'd0, field_d};
      default:    lock_mode_d = MODE_IDLE;
    endcase
  end

  // control and result registers
  logic [3:0] lock_mode_q;
  logic [1:0] edit_digits_q, set_field_q;
  logic       set_valid_q;
  logic [5:0] set_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q       <= ST_IDLE;
      pos_q         <= '0;
      field_q       <= FIELD_HOUR;
      tick_q        <= '0;
      phase_q       <= '0;
      ecnt_q        <= '0;
      lock_mode_q   <= MODE_IDLE;
      edit_digits_q <= '0;
      set_valid_q   <= 1'b0;
      set_field_q   <= '0;
      set_value_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        state_q       <= state_d;
        pos_q         <= pos_d;
        field_q       <= field_d;
        tick_q        <= tick_d;
        phase_q       <= phase_d;
        ecnt_q        <= ecnt_d;
        lock_mode_q   <= lock_mode_d;
        edit_digits_q <= ecnt_d;
        set_valid_q   <= set_valid_d;
        set_field_q   <= set_field_d;
        set_value_q   <= set_value_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // key stores, written only when a key is taken
  always_ff @(posedge clk_i) begin
    if (advance && code_wr) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        if ((state_q != ST_ENTRY && i == 0) ||
            (state_q == ST_ENTRY && pos_q == PosW'(i))) begin
          code_q[i] <= key_q;
        end
      end
    end
    if (advance && ebuf_wr) begin
      ebuf_q[ecnt_q[0]] <= key_q[3:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign lock_mode_o   = lock_mode_q;
  assign edit_digits_o = edit_digits_q;
  assign set_valid_o   = set_valid_q;
  assign set_field_o   = set_field_q;
  assign set_value_o   = set_value_q;

  // checks
  `KCL_ASSERT(a_set_idle, (out_valid_o && set_valid_o) |-> (lock_mode_o == MODE_IDLE), "time write outside idle")
  `KCL_ASSERT(a_set_range, set_valid_o |-> ((set_value_o <= 6'd59) && (set_field_o <= 2'd2)), "time write out of range")
  `KCL_ASSERT(a_ecnt_edit, (ecnt_q != 2'd0) |-> (state_q == ST_EDIT), "edit digits outside edit")
  `KCL_ASSERT_NEXT(a_check_end, (state_q == ST_CHECK) && advance, (state_q == ST_GRANTED) || (state_q == ST_DENIED), "code check did not resolve")
  `KCL_ASSERT(a_phase, {1'b0, phase_q} < SCAN_LAST, "scan phase out of range")

endmodule
